### rtl/core/bcpe_pkg.sv
// Shared types and constants for the Bezier curve point evaluator.
// No dependencies; used by bezier_curve_point_eval.
package bcpe_pkg;

  // Coordinate format: signed Q1.14
  localparam int CoordW = 16;
  // Curve parameter: unsigned, 16 fraction bits, 1.0 = 2^16
  localparam int ParamW = 17;
  localparam logic [ParamW-1:0] ParamOne = 17'h10000;

  // Control point storage
  localparam int MaxPoints = 4;
  localparam int AxisCount = 2;
  localparam int RegCount  = MaxPoints * AxisCount;
  localparam int RegIdxW   = $clog2(RegCount);

  // Axis codes within a point
  localparam int AxisX = 0;
  localparam int AxisY = 1;

  // Interpolation arithmetic
  localparam int DiffW = CoordW + 1;             // b - a
  localparam int ProdW = ParamW + 1 + DiffW;     // signed t times difference
  localparam int FracW = 16;                     // fraction bits of t
  localparam logic signed [ProdW-1:0] RoundHalf = ProdW'(35'sd32768);
  localparam int StepW = ProdW - FracW;          // rounded step width
  localparam int SumW  = StepW + 1;

  // Stream widths (padded to whole bytes)
  localparam int InDataW  = 24;
  localparam int OutDataW = 32;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef coord_t [AxisCount-1:0] point_t;
  typedef point_t [MaxPoints-1:0] point_set_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef prod_t [AxisCount-1:0] prod_pair_t;
  typedef prod_pair_t [MaxPoints-1:0] prod_set_t;

endpackage

### rtl/core/bezier_curve_point_eval.sv
// Bezier curve point evaluator, de Casteljau scheme, fully pipelined.
// Depends on bcpe_pkg for types and constants.
//
// Usage:
//   Control points are written through the plain register port (cfg_we_i,
//   cfg_idx_i, cfg_wdata_i): index 2*i is x and 2*i+1 is y of point i,
//   signed Q1.14. Write them only while no beat is in flight.
//   Each input beat carries the curve parameter t (17 bits, 2^16 = 1.0;
//   larger codes saturate to 1.0). Each output beat carries the point on
//   the curve built from the first POINT_COUNT control points.
// Pipeline: an input stage saturates t; each interpolation round takes two
//   stages: one holds the t*(b-a) products, the next rounds and adds.
// Throughput: one beat per cycle, sustained while the receiver holds m_axis_tready_i high.
// Reset: all stage valid bits clear and the control points read zero.
// Stall: when the receiver holds m_axis_tready_i low, the output beat
//   holds; earlier stages keep filling any empty slots, so input is still
//   taken until every stage is occupied. Nothing is dropped or repeated.
module bezier_curve_point_eval #(
  parameter int POINT_COUNT = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port
  input  logic                                cfg_we_i,
  input  logic [bcpe_pkg::RegIdxW-1:0]        cfg_idx_i,
  input  logic [bcpe_pkg::CoordW-1:0]         cfg_wdata_i,
  // Input stream
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [bcpe_pkg::InDataW-1:0]        s_axis_tdata_i,  // [16:0] curve_param
  // Output stream
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [bcpe_pkg::OutDataW-1:0]       m_axis_tdata_o   // [15:0] curve_x, [31:16] curve_y
);

  localparam int PointsUsed = (POINT_COUNT < 2) ? 2 :
                              (POINT_COUNT > bcpe_pkg::MaxPoints) ? bcpe_pkg::MaxPoints :
                              POINT_COUNT;
  localparam int Rounds     = PointsUsed - 1;
  localparam int StageCount = 1 + 2 * Rounds;

  // Control point registers
  bcpe_pkg::coord_t cfg_q [bcpe_pkg::RegCount];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < bcpe_pkg::RegCount; r++) begin
        cfg_q[r] <= '0;
      end
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  // Handshake chain: a stage loads when empty or when its successor moves
  logic [StageCount:0]   rdy;
  logic [StageCount-1:0] valid_q, valid_d, valid_in;

  assign rdy[StageCount] = m_axis_tready_i;

  for (genvar s = 0; s < StageCount; s++) begin : g_ctrl
    assign rdy[s] = ~valid_q[s] | rdy[s+1];
    if (s == 0) begin : g_first
      assign valid_in[s] = s_axis_tvalid_i;
    end else begin : g_next
      assign valid_in[s] = valid_q[s-1];
    end
    assign valid_d[s] = rdy[s] ? valid_in[s] : valid_q[s];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign s_axis_tready_o = rdy[0];
  assign m_axis_tvalid_o = valid_q[StageCount-1];

  // Input stage: saturate t to one
  logic [bcpe_pkg::ParamW-1:0] curve_param;
  logic [bcpe_pkg::ParamW-1:0] t0_d, t0_q;

  assign curve_param = s_axis_tdata_i[bcpe_pkg::ParamW-1:0];
  assign t0_d = (curve_param > bcpe_pkg::ParamOne) ? bcpe_pkg::ParamOne : curve_param;

  always_ff @(posedge clk_i) begin
    if (rdy[0] && s_axis_tvalid_i) begin
      t0_q <= t0_d;
    end
  end

  // Round sources: round 0 reads the control points, later rounds the
  // previous round's results
  bcpe_pkg::point_set_t        src_pts [Rounds+1];
  logic [bcpe_pkg::ParamW-1:0] src_t   [Rounds+1];

  for (genvar p = 0; p < bcpe_pkg::MaxPoints; p++) begin : g_cfg_pts
    assign src_pts[0][p][bcpe_pkg::AxisX] = cfg_q[p * bcpe_pkg::AxisCount + bcpe_pkg::AxisX];
    assign src_pts[0][p][bcpe_pkg::AxisY] = cfg_q[p * bcpe_pkg::AxisCount + bcpe_pkg::AxisY];
  end
  assign src_t[0] = t0_q;

  for (genvar r = 0; r < Rounds; r++) begin : g_round
    localparam int StA = 1 + 2 * r;
    localparam int StB = 2 + 2 * r;

    bcpe_pkg::point_set_t        base_q, pts_d, pts_q;
    bcpe_pkg::prod_set_t         prod_d, prod_q;
    logic [bcpe_pkg::ParamW-1:0] ta_q, tb_q;

    // Stage A: difference to the next point, scaled by t
    always_comb begin
      logic signed [bcpe_pkg::ParamW:0]  t_s;
      logic signed [bcpe_pkg::DiffW-1:0] diff;
      t_s    = $signed({1'b0, src_t[r]});
      prod_d = '0;
      diff   = '0;
      for (int i = 0; i < bcpe_pkg::MaxPoints - 1; i++) begin
        for (int c = 0; c < bcpe_pkg::AxisCount; c++) begin
          diff = {src_pts[r][i+1][c][bcpe_pkg::CoordW-1], src_pts[r][i+1][c]}
               - {src_pts[r][i][c][bcpe_pkg::CoordW-1], src_pts[r][i][c]};
          prod_d[i][c] = t_s * diff;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[StA] && valid_in[StA]) begin
        ta_q   <= src_t[r];
        base_q <= src_pts[r];
        prod_q <= prod_d;
      end
    end

    // Stage B: round to nearest (ties up) and add to the base point
    always_comb begin
      logic signed [bcpe_pkg::ProdW-1:0] rnd;
      logic signed [bcpe_pkg::StepW-1:0] step;
      logic signed [bcpe_pkg::SumW-1:0]  sum;
      pts_d = base_q;
      rnd   = '0;
      step  = '0;
      sum   = '0;
      for (int i = 0; i < bcpe_pkg::MaxPoints - 1; i++) begin
        for (int c = 0; c < bcpe_pkg::AxisCount; c++) begin
          rnd  = prod_q[i][c] + bcpe_pkg::RoundHalf;
          step = rnd[bcpe_pkg::ProdW-1:bcpe_pkg::FracW];
          sum  = {{(bcpe_pkg::SumW - bcpe_pkg::CoordW){base_q[i][c][bcpe_pkg::CoordW-1]}},
                  base_q[i][c]}
               + {step[bcpe_pkg::StepW-1], step};
          pts_d[i][c] = sum[bcpe_pkg::CoordW-1:0];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[StB] && valid_in[StB]) begin
        tb_q  <= ta_q;
        pts_q <= pts_d;
      end
    end

    assign src_pts[r+1] = pts_q;
    assign src_t[r+1]   = tb_q;
  end

  // Output beat: first point of the last round
  assign m_axis_tdata_o = {src_pts[Rounds][0][bcpe_pkg::AxisY],
                           src_pts[Rounds][0][bcpe_pkg::AxisX]};

endmodule

### dv/tb_bezier_curve_point_eval.sv
// Self-checking testbench for bezier_curve_point_eval: streams curve parameters in,
// predicts each cubic de Casteljau point in the bench and compares it with the output beats.
// Depends on bcpe_pkg and the bezier_curve_point_eval RTL.
module tb_bezier_curve_point_eval;

  localparam int CurvePoints = 4;
  localparam int IdleLimit   = 2000;
  localparam int DrainCycles = 20;
  localparam int ReportMax   = 10;
  localparam int SetItems    = 62;

  typedef logic [bcpe_pkg::ParamW-1:0] param_t;
  typedef struct packed {
    param_t           t;
    bcpe_pkg::coord_t x;
    bcpe_pkg::coord_t y;
  } curve_point_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [bcpe_pkg::RegIdxW-1:0]   cfg_idx_i;
  logic [bcpe_pkg::CoordW-1:0]    cfg_wdata_i;
  logic                           s_axis_tvalid_i;
  logic                           s_axis_tready_o;
  logic [bcpe_pkg::InDataW-1:0]   s_axis_tdata_i;   // [16:0] curve_param
  logic                           m_axis_tvalid_o;
  logic                           m_axis_tready_i;
  logic [bcpe_pkg::OutDataW-1:0]  m_axis_tdata_o;   // [15:0] curve_x, [31:16] curve_y

  // Bench copy of the control point registers and the points still owed
  bcpe_pkg::coord_t point_regs [bcpe_pkg::RegCount] = '{default: '0};
  curve_point_t     pending_points [$];

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int params_taken    = 0;
  int points_checked  = 0;
  int point_sets      = 0;
  int mismatch_count  = 0;
  int idle_cycles     = 0;

  curve_point_t     want_point;
  bcpe_pkg::coord_t got_x;
  bcpe_pkg::coord_t got_y;

  bezier_curve_point_eval #(
    .POINT_COUNT(CurvePoints)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // a + round(t*(b-a)), ties toward plus infinity
  function automatic bcpe_pkg::coord_t lerp_round(bcpe_pkg::coord_t a, bcpe_pkg::coord_t b,
                                                  param_t t);
    longint signed span;
    longint signed prod;
    span = longint'(b) - longint'(a);
    prod = longint'(t) * span + 64'sd32768;
    return bcpe_pkg::coord_t'(longint'(a) + (prod >>> bcpe_pkg::FracW));
  endfunction

  // Reduce the control points to one curve point at t
  function automatic curve_point_t eval_curve_point(param_t t_raw);
    bcpe_pkg::coord_t xs [bcpe_pkg::MaxPoints];
    bcpe_pkg::coord_t ys [bcpe_pkg::MaxPoints];
    param_t           t_sat;
    curve_point_t     pt;
    t_sat = (t_raw > bcpe_pkg::ParamOne) ? bcpe_pkg::ParamOne : t_raw;
    for (int i = 0; i < bcpe_pkg::MaxPoints; i++) begin
      xs[i] = point_regs[i*bcpe_pkg::AxisCount + bcpe_pkg::AxisX];
      ys[i] = point_regs[i*bcpe_pkg::AxisCount + bcpe_pkg::AxisY];
    end
    for (int k = 1; k < CurvePoints; k++) begin
      for (int i = 0; i < CurvePoints - k; i++) begin
        xs[i] = lerp_round(xs[i], xs[i+1], t_sat);
        ys[i] = lerp_round(ys[i], ys[i+1], t_sat);
      end
    end
    pt.t = t_raw;
    pt.x = xs[0];
    pt.y = ys[0];
    return pt;
  endfunction

  function automatic bcpe_pkg::coord_t rand_coord();
    unique case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return '0;
      default: return bcpe_pkg::coord_t'($urandom);
    endcase
  endfunction

  // Mostly in-range t, with the ends and saturating codes mixed in
  function automatic param_t rand_param();
    unique case ($urandom_range(0, 9))
      0:       return '0;
      1:       return bcpe_pkg::ParamOne;
      2:       return param_t'($urandom_range(bcpe_pkg::ParamOne + 1,
                                              2**bcpe_pkg::ParamW - 1));
      3:       return param_t'($urandom);
      default: return param_t'($urandom_range(0, bcpe_pkg::ParamOne));
    endcase
  endfunction

  // Predict on every accepted input beat; track register writes
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        pending_points = {pending_points,
                          eval_curve_point(s_axis_tdata_i[bcpe_pkg::ParamW-1:0])};
        params_taken++;
      end
      if (cfg_we_i) point_regs[cfg_idx_i] = cfg_wdata_i;
    end
  end

  // Compare each output beat with the oldest owed point
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got_x = m_axis_tdata_o[bcpe_pkg::CoordW-1:0];
      got_y = m_axis_tdata_o[2*bcpe_pkg::CoordW-1:bcpe_pkg::CoordW];
      if (pending_points.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ReportMax)
          $display("ERROR: unexpected point x=%0d y=%0d", got_x, got_y);
      end else begin
        want_point = pending_points.pop_front();
        points_checked++;
        if (want_point.x !== got_x || want_point.y !== got_y) begin
          mismatch_count++;
          if (mismatch_count <= ReportMax)
            $display("ERROR: t=0x%05h expected x=%0d y=%0d, got x=%0d y=%0d",
                     want_point.t, want_point.x, want_point.y, got_x, got_y);
        end
      end
    end
  end

  // Randomise receiver backpressure
  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Abort when no beat moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        cfg_we_i) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("ERROR: no beat moved for %0d cycles", IdleLimit);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Offer one curve parameter and hold it until taken
  task automatic send_param(input param_t t);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= bcpe_pkg::InDataW'(t);
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // Drop valid, let the last taken beat be booked, then wait for every owed point
  task automatic drain_points();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_points.size() != 0) @(posedge clk_i);
  endtask

  task automatic load_control_points(input bcpe_pkg::point_set_t pts);
    for (int i = 0; i < bcpe_pkg::MaxPoints; i++) begin
      for (int a = 0; a < bcpe_pkg::AxisCount; a++) begin
        cfg_we_i    <= 1'b1;
        cfg_idx_i   <= bcpe_pkg::RegIdxW'(i*bcpe_pkg::AxisCount + a);
        cfg_wdata_i <= pts[i][a];
        @(posedge clk_i);
      end
    end
    cfg_we_i <= 1'b0;
    point_sets++;
  endtask

  // Reset leaves all control points at the origin
  task automatic test_reset_state();
    send_param('0);
    send_param(bcpe_pkg::ParamOne);
    drain_points();
  endtask

  // Alternate full-scale corners, sweep t across its ends and saturating codes
  task automatic test_extreme_points();
    bcpe_pkg::point_set_t pts;
    for (int i = 0; i < bcpe_pkg::MaxPoints; i++) begin
      pts[i][bcpe_pkg::AxisX] = (i % 2 == 0) ? 16'sh8000 : 16'sh7FFF;
      pts[i][bcpe_pkg::AxisY] = (i % 2 == 0) ? 16'sh7FFF : 16'sh8000;
    end
    load_control_points(pts);
    send_param('0);
    send_param(17'd1);
    send_param(17'h0AAAA);
    send_param(17'h08000);
    send_param(17'h0FFFF);
    send_param(bcpe_pkg::ParamOne);
    send_param(17'h10001);
    send_param(17'h15555);
    send_param(17'h1FFFF);
    drain_points();
  endtask

  // Unit steps make half-code ties round upward on both signs
  task automatic test_rounding_ties();
    bcpe_pkg::point_set_t pts;
    pts[0][bcpe_pkg::AxisX] = 16'sd0;
    pts[0][bcpe_pkg::AxisY] = 16'sd0;
    for (int i = 1; i < bcpe_pkg::MaxPoints; i++) begin
      pts[i][bcpe_pkg::AxisX] = 16'sd1;
      pts[i][bcpe_pkg::AxisY] = -16'sd1;
    end
    load_control_points(pts);
    send_param(17'h08000);
    send_param(17'h04000);
    send_param(17'h0C000);
    send_param(17'd1);
    send_param(17'h0FFFF);
    drain_points();
  endtask

  // Two random control point sets per idling mix
  task automatic test_random_curves(input int sender_pct, input int recv_pct);
    bcpe_pkg::point_set_t pts;
    sender_idle_pct = sender_pct;
    recv_stall_pct  = recv_pct;
    repeat (2) begin
      for (int i = 0; i < bcpe_pkg::MaxPoints; i++) begin
        pts[i][bcpe_pkg::AxisX] = rand_coord();
        pts[i][bcpe_pkg::AxisY] = rand_coord();
      end
      load_control_points(pts);
      repeat (SetItems) send_param(rand_param());
      drain_points();
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_wdata_i     = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    m_axis_tready_i = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_extreme_points();
    test_rounding_ties();
    test_random_curves(0, 0);
    test_random_curves(52, 0);
    test_random_curves(0, 52);
    test_random_curves(28, 28);

    drain_points();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d curve parameters over %0d control point sets, checked %0d points",
             params_taken, point_sets, points_checked);
    $display("Idling mixes: none, sender 52%%, receiver 52%%, both 28%%; mismatches: %0d",
             mismatch_count);
    if (mismatch_count == 0 && pending_points.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/bcpe_pkg.sv
rtl/core/bezier_curve_point_eval.sv
dv/tb_bezier_curve_point_eval.sv
